FILE: hw/rtl/mep_pkg.sv
// Package for the Mandelbrot escape-time pixel colorer.
// Types, constants and helper functions shared by all mep_* modules.
// No dependencies.
`default_nettype none

package mep_pkg;

  // field widths
  localparam int COL_W      = 11;
  localparam int ROW_W      = 10;
  localparam int FX_W       = 64;
  localparam int STEP_W     = 63;
  localparam int ITER_W     = 16;
  localparam int CW_W       = 12;
  localparam int OFF_W      = 16;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // divider sizing: numerator covers mult*k (< 2^20), denominator covers 3*width
  localparam int DIV_N_W = 20;
  localparam int DIV_D_W = 14;
  localparam int KSUM_W  = ITER_W + 1;

  // short queue between front and back (power of two)
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Q4.60 constants
  localparam logic signed [FX_W-1:0] Q_ONE       = 64'sh1000_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_MONE      = 64'shF000_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_MTWO      = 64'shE000_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_HALF      = 64'sh0800_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_QUARTER   = 64'sh0400_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_SIXTEENTH = 64'sh0100_0000_0000_0000;
  localparam logic signed [FX_W-1:0] Q_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [FX_W-1:0] Q_MIN       = 64'sh8000_0000_0000_0000;
  localparam logic [FX_W:0]          Q_FOUR_U    = 65'h0_4000_0000_0000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P_MIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_MIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_OFFSET = 3'd5;

  // register reset values
  localparam logic [ITER_W-1:0] MAX_ITER_RST     = 16'd24000;
  localparam logic [CW_W-1:0]   COLOR_WIDTH_RST  = 12'd666;
  localparam logic [OFF_W-1:0]  COLOR_OFFSET_RST = 16'd3200;

  // palette segment and channel codes
  localparam logic [1:0] SEG_LOW   = 2'd0;
  localparam logic [1:0] SEG_MID   = 2'd1;
  localparam logic [1:0] SEG_HIGH  = 2'd2;
  localparam logic [1:0] CH_BLUE   = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_RED    = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            inside_res;
  } out_t;

  typedef struct packed {
    logic signed [FX_W-1:0] p_min;
    logic signed [FX_W-1:0] q_min;
    logic [STEP_W-1:0]      step;
  } fcfg_t;

  typedef struct packed {
    logic [ITER_W-1:0] max_iterations;
    logic [CW_W-1:0]   color_width;
    logic [OFF_W-1:0]  color_offset;
  } bcfg_t;

  typedef struct packed {
    logic signed [FX_W-1:0] p;
    logic signed [FX_W-1:0] q;
  } pq_t;

  typedef struct packed {
    logic [CH_W-1:0] base;
    logic [CH_W-1:0] mult;
    logic            sub;
  } coef_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PROD,
    F_ADD,
    F_PUSH
  } f_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_PRE_A,
    B_PRE_AW,
    B_PRE_R2,
    B_PRE_R2A,
    B_PRE_B,
    B_PRE_BW,
    B_CHECK,
    B_IT_A,
    B_IT_AW,
    B_IT_B,
    B_IT_BW,
    B_MOD,
    B_MODW,
    B_SEG,
    B_CH,
    B_CHW,
    B_DONE
  } b_state_t;

  // linear ramp: channel = base +/- mult*k/width
  function automatic coef_t color_coef(input logic [1:0] seg, input logic [1:0] ch);
    coef_t c;
    c = '0;
    unique case ({seg, ch})
      {SEG_LOW,  CH_BLUE}:  c = '{base: 8'd116, mult: 8'd139, sub: 1'b0};
      {SEG_LOW,  CH_GREEN}: c = '{base: 8'd11,  mult: 8'd244, sub: 1'b0};
      {SEG_LOW,  CH_RED}:   c = '{base: 8'd0,   mult: 8'd237, sub: 1'b0};
      {SEG_MID,  CH_BLUE}:  c = '{base: 8'd255, mult: 8'd253, sub: 1'b1};
      {SEG_MID,  CH_GREEN}: c = '{base: 8'd255, mult: 8'd123, sub: 1'b1};
      {SEG_MID,  CH_RED}:   c = '{base: 8'd238, mult: 8'd0,   sub: 1'b0};
      {SEG_HIGH, CH_BLUE}:  c = '{base: 8'd2,   mult: 8'd114, sub: 1'b0};
      {SEG_HIGH, CH_GREEN}: c = '{base: 8'd132, mult: 8'd121, sub: 1'b1};
      {SEG_HIGH, CH_RED}:   c = '{base: 8'd239, mult: 8'd239, sub: 1'b1};
      default:              c = '0;
    endcase
    return c;
  endfunction

  // saturating signed 64-bit add
  function automatic logic signed [FX_W-1:0] sadd64(input logic signed [FX_W-1:0] a,
                                                   input logic signed [FX_W-1:0] b);
    logic signed [FX_W:0] s;
    logic signed [FX_W-1:0] r;
    s = {a[FX_W-1], a} + {b[FX_W-1], b};
    if (s[FX_W] != s[FX_W-1]) begin
      r = s[FX_W] ? Q_MIN : Q_MAX;
    end else begin
      r = s[FX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_pixel_colorer_core.sv
// Mandelbrot escape-time pixel colorer, top level.
// Holds the configuration registers; instantiates mep_front, mep_fifo, mep_back.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries a pixel (column, row).
//    The front end forms c in Q4.60 and queues it; in_stall is high while
//    the front end holds an item.
//  - Output channel out_valid/out_stall/out_data gives one BGR color plus
//    inside_res per item, in order. The output register is held while
//    out_stall is high; the back end keeps working and parks its next
//    result until the register frees up.
//  - Config port: cfg_we/cfg_index/cfg_wdata, one register per write, only
//    while no item is in flight. Unknown indexes are dropped.
//  - Processing: the front end forms the point, then the back end runs the
//    cardioid/bulb precheck, then the escape iterations (two rounds of the
//    partial-product multipliers per iteration), then the palette (four
//    20-bit divisions). Points caught by the precheck skip the iterations
//    and the palette.
//  - Throughput is one item per back-end pass; meanwhile the front end can
//    take up to three more items (two in the queue, one held in the front).
//  - Reset (rst_n low, synchronous) empties the queue, drops any result and
//    loads the register defaults.
`default_nettype none

module mandelbrot_escape_pixel_colorer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mep_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mep_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mep_pkg::*;

  // configuration registers
  logic signed [FX_W-1:0] p_min_r, q_min_r;
  logic [STEP_W-1:0]      step_r;
  logic [ITER_W-1:0]      max_iter_r;
  logic [CW_W-1:0]        color_width_r;
  logic [OFF_W-1:0]       color_offset_r;

  fcfg_t fcfg;
  bcfg_t bcfg;

  logic q_push, q_full, q_pop, q_empty;
  pq_t  q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_min_r        <= '0;
      q_min_r        <= '0;
      step_r         <= '0;
      max_iter_r     <= MAX_ITER_RST;
      color_width_r  <= COLOR_WIDTH_RST;
      color_offset_r <= COLOR_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_MIN:        p_min_r        <= cfg_wdata;
        REG_Q_MIN:        q_min_r        <= cfg_wdata;
        REG_STEP:         step_r         <= cfg_wdata[STEP_W-1:0];
        REG_MAX_ITER:     max_iter_r     <= cfg_wdata[ITER_W-1:0];
        REG_COLOR_WIDTH:  color_width_r  <= cfg_wdata[CW_W-1:0];
        REG_COLOR_OFFSET: color_offset_r <= cfg_wdata[OFF_W-1:0];
        default: ;  // write to an unused index is ignored
      endcase
    end
  end

  assign fcfg = '{p_min: p_min_r, q_min: q_min_r, step: step_r};
  assign bcfg = '{max_iterations: max_iter_r, color_width: color_width_r,
                  color_offset: color_offset_r};

  // front: accept and form the point
  mep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (fcfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  // decouples front from the long-running back end
  mep_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back: precheck, iterate, color, output register
  mep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (bcfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue is never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("point queue overflow");

  // queue is never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("point queue underflow");

  // a point judged inside is painted black
  a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.inside_res) |->
      (out_data.blue == '0 && out_data.green == '0 && out_data.red == '0))
    else $error("inside point with nonzero color");

  // front end takes one item at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front end accepted two items back to back");

endmodule

`default_nettype wire

FILE: hw/rtl/mep_mul.sv
// Multi-cycle signed Q4.60 multiplier: floor(a*b / 2^s), saturated, s = 59 or 60.
// One 32x32 partial product per cycle. Depends on mep_pkg.
`default_nettype none

module mep_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            s59,
  input  logic signed [mep_pkg::FX_W-1:0] a,
  input  logic signed [mep_pkg::FX_W-1:0] b,
  output logic                            done,
  output logic signed [mep_pkg::FX_W-1:0] res
);
  import mep_pkg::*;

  localparam logic [2:0] LAST_PP  = 3'd3;
  localparam logic [2:0] LAST_ACC = 3'd4;
  localparam logic [2:0] NEG_STEP = 3'd5;
  localparam logic [2:0] SAT_STEP = 3'd6;

  logic                   busy_r;
  logic [2:0]             cnt_r;
  logic                   done_r;
  logic [FX_W-1:0]        ua_r, ub_r;
  logic                   neg_r, s59_r;
  logic [FX_W-1:0]        pp_r;
  logic [1:0]             psh_r;
  logic [2*FX_W-1:0]      acc_r;
  logic [2*FX_W-1:0]      sgn_r;
  logic signed [FX_W-1:0] res_r;

  logic [FX_W/2-1:0]        a_half, b_half;
  logic [FX_W-1:0]          pp_nxt;
  logic [2*FX_W-1:0]        pp_sh;
  logic [2*FX_W-1:0]        acc_nxt;
  logic signed [2*FX_W-1:0] sh;
  logic [FX_W-1:0]          mag_a, mag_b;
  logic signed [FX_W-1:0]   sat_val;

  always_comb begin
    mag_a  = a[FX_W-1] ? (~a + 64'd1) : a;
    mag_b  = b[FX_W-1] ? (~b + 64'd1) : b;
    a_half = cnt_r[1] ? ua_r[FX_W-1:FX_W/2] : ua_r[FX_W/2-1:0];
    b_half = cnt_r[0] ? ub_r[FX_W-1:FX_W/2] : ub_r[FX_W/2-1:0];
    pp_nxt = {32'd0, a_half} * {32'd0, b_half};
    unique case (psh_r)
      2'd2:    pp_sh = {pp_r, 64'd0};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {64'd0, pp_r};
    endcase
    acc_nxt = acc_r + pp_sh;
    sh = s59_r ? ($signed(sgn_r) >>> 59) : ($signed(sgn_r) >>> 60);
    if (!sh[2*FX_W-1] && (|sh[2*FX_W-2:FX_W-1])) begin
      sat_val = Q_MAX;
    end else if (sh[2*FX_W-1] && !(&sh[2*FX_W-2:FX_W-1])) begin
      sat_val = Q_MIN;
    end else begin
      sat_val = sh[FX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == SAT_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= mag_a;
      ub_r  <= mag_b;
      neg_r <= a[FX_W-1] ^ b[FX_W-1];
      s59_r <= s59;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r <= LAST_PP) begin
        pp_r  <= pp_nxt;
        psh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r != 3'd0 && cnt_r <= LAST_ACC) begin
        acc_r <= acc_nxt;
      end
      if (cnt_r == NEG_STEP) begin
        sgn_r <= neg_r ? (128'd0 - acc_r) : acc_r;
      end
      if (cnt_r == SAT_STEP) begin
        res_r <= sat_val;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mep_div.sv
// Restoring divider, one quotient bit per cycle, for the palette math.
// Depends on mep_pkg.
`default_nettype none

module mep_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mep_pkg::DIV_N_W-1:0] num,
  input  logic [mep_pkg::DIV_D_W-1:0] den,
  output logic                       done,
  output logic [mep_pkg::DIV_N_W-1:0] quo,
  output logic [mep_pkg::DIV_D_W-1:0] rem
);
  import mep_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy_r, done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] rem_r, den_r;

  logic [DIV_D_W:0]   shl;
  logic [DIV_D_W+1:0] diff;
  logic               ge;

  always_comb begin
    shl  = {rem_r, quo_r[DIV_N_W-1]};
    diff = {1'b0, shl} - {2'b00, den_r};
    ge   = !diff[DIV_D_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N_W-2:0], ge};
      rem_r <= ge ? diff[DIV_D_W-1:0] : shl[DIV_D_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mep_fifo.sv
// Short queue of point coordinates between the front and the back end.
// Depends on mep_pkg.
`default_nettype none

module mep_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mep_pkg::pq_t push_data,
  output logic         full,
  input  logic         pop,
  output mep_pkg::pq_t pop_data,
  output logic         empty
);
  import mep_pkg::*;

  pq_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign full     = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/mep_front.sv
// Front end: accepts a pixel item and forms c = (p_min + col*step, q_min + row*step).
// Pushes the point into the queue. Depends on mep_pkg.
`default_nettype none

module mep_front (
  input  logic           clk,
  input  logic           rst_n,
  input  mep_pkg::fcfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  mep_pkg::in_t   in_data,
  output logic           q_push,
  output mep_pkg::pq_t   q_data,
  input  logic           q_full
);
  import mep_pkg::*;

  f_state_t state_r, state_nxt;

  // partial products: index times low / high half of step
  logic [COL_W+31:0] ppcl_r;
  logic [COL_W+30:0] ppch_r;
  logic [ROW_W+31:0] pprl_r;
  logic [ROW_W+30:0] pprh_r;
  logic [FX_W-1:0]   pc_r, qc_r;
  logic [FX_W-1:0]   p_r, q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = F_PROD;
        end
      end
      F_PROD: state_nxt = F_ADD;
      F_ADD:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        ppcl_r <= (COL_W+32)'(in_data.column) * (COL_W+32)'(cfg.step[31:0]);
        ppch_r <= (COL_W+31)'(in_data.column) * (COL_W+31)'(cfg.step[STEP_W-1:32]);
        pprl_r <= (ROW_W+32)'(in_data.row) * (ROW_W+32)'(cfg.step[31:0]);
        pprh_r <= (ROW_W+31)'(in_data.row) * (ROW_W+31)'(cfg.step[STEP_W-1:32]);
      end
      F_PROD: begin
        pc_r <= {ppch_r[31:0], 32'd0} + {{(FX_W-COL_W-32){1'b0}}, ppcl_r};
        qc_r <= {pprh_r[31:0], 32'd0} + {{(FX_W-ROW_W-32){1'b0}}, pprl_r};
      end
      F_ADD: begin
        p_r <= cfg.p_min + pc_r;
        q_r <= cfg.q_min + qc_r;
      end
      default: ;
    endcase
  end

  assign q_data.p = p_r;
  assign q_data.q = q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mep_back.sv
// Back end: cardioid/bulb precheck, escape iteration and palette lookup.
// Uses mep_mul (x3) and mep_div; depends on mep_pkg.
`default_nettype none

module mep_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mep_pkg::bcfg_t cfg,
  input  logic           q_empty,
  output logic           q_pop,
  input  mep_pkg::pq_t   q_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mep_pkg::out_t  out_data
);
  import mep_pkg::*;

  b_state_t state_r, state_nxt;

  logic signed [FX_W-1:0] p_r, q_r, a_r, b_r;
  logic                   rc_r, rb_r, bulb_r;
  logic signed [FX_W-1:0] aa_r, qq_r, bb_r, r2_r, r2a_r;
  logic signed [FX_W-1:0] x_r, y_r, xn_r, x2_r, dxy_r;
  logic [FX_W:0]          esc_r;
  logic [ITER_W-1:0]      n_r;
  logic [DIV_D_W-1:0]     k_r;
  logic [CW_W-1:0]        kk_r;
  logic [1:0]             seg_r, ch_r;
  out_t                   res_r;
  logic                   ovld_r;
  out_t                   odata_r;

  // multiplier hookup
  logic                   m_start, m2_s59;
  logic signed [FX_W-1:0] m0_a, m0_b, m1_a, m2_a, m2_b;
  logic                   m0_done, m1_done, m2_done;
  logic signed [FX_W-1:0] m0_res, m1_res, m2_res;

  // divider hookup
  logic                 d_start, d_done;
  logic [DIV_N_W-1:0]   d_num, d_quo;
  logic [DIV_D_W-1:0]   d_den, d_rem;

  logic [CW_W-1:0]      cw_eff;
  logic [DIV_D_W-1:0]   cw1, cw2, cw3;
  logic [KSUM_W-1:0]    ksum;
  coef_t                coef;
  logic [CH_W-1:0]      ch_val;
  logic                 q_ok, rc_in, rb_in, card, go_on;
  logic                 out_load;

  always_comb begin
    cw_eff = (cfg.color_width == '0) ? CW_W'(1) : cfg.color_width;
    cw1    = DIV_D_W'(cw_eff);
    cw2    = {1'b0, cw_eff, 1'b0};
    cw3    = cw1 + cw2;
    ksum   = {1'b0, n_r} + {1'b0, cfg.color_offset};
    coef   = color_coef(seg_r, ch_r);
    ch_val = coef.sub ? (coef.base - d_quo[CH_W-1:0]) : (coef.base + d_quo[CH_W-1:0]);
    q_ok   = (q_data.q >= Q_MONE) && (q_data.q < Q_ONE);
    rc_in  = q_ok && (q_data.p >= Q_MONE) && (q_data.p < Q_HALF);
    rb_in  = q_ok && (q_data.p >= Q_MTWO) && (q_data.p < 0);
    card   = rc_r && (m0_res < (qq_r >>> 2));
    go_on  = (esc_r < Q_FOUR_U) && (n_r < cfg.max_iterations);
    out_load = (state_r == B_DONE) && (!ovld_r || !out_stall);
  end

  // operand steering per state
  always_comb begin
    m_start = (state_r == B_PRE_A) || (state_r == B_PRE_B) ||
              (state_r == B_IT_A)  || (state_r == B_IT_B);
    m2_s59  = (state_r == B_IT_A);
    unique case (state_r)
      B_PRE_A: begin
        m0_a = a_r;  m0_b = a_r;
      end
      B_PRE_B: begin
        m0_a = r2_r; m0_b = r2a_r;
      end
      default: begin
        m0_a = xn_r; m0_b = xn_r;
      end
    endcase
    m1_a = (state_r == B_PRE_A) ? q_r : y_r;
    m2_a = (state_r == B_PRE_A) ? b_r : x_r;
    m2_b = (state_r == B_PRE_A) ? b_r : y_r;
    d_start = (state_r == B_MOD) || (state_r == B_CH);
    if (state_r == B_MOD) begin
      d_num = DIV_N_W'(ksum);
      d_den = cw3;
    end else begin
      d_num = DIV_N_W'(coef.mult) * DIV_N_W'(kk_r);
      d_den = cw1;
    end
  end

  mep_mul u_mul0 (
    .clk(clk), .rst_n(rst_n), .start(m_start), .s59(1'b0),
    .a(m0_a), .b(m0_b), .done(m0_done), .res(m0_res)
  );

  mep_mul u_mul1 (
    .clk(clk), .rst_n(rst_n), .start(m_start), .s59(1'b0),
    .a(m1_a), .b(m1_a), .done(m1_done), .res(m1_res)
  );

  mep_mul u_mul2 (
    .clk(clk), .rst_n(rst_n), .start(m_start), .s59(m2_s59),
    .a(m2_a), .b(m2_b), .done(m2_done), .res(m2_res)
  );

  mep_div u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
    .done(d_done), .quo(d_quo), .rem(d_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_PRE_A;
        end
      end
      B_PRE_A:   state_nxt = B_PRE_AW;
      B_PRE_AW:  if (m0_done && m1_done && m2_done) state_nxt = B_PRE_R2;
      B_PRE_R2:  state_nxt = B_PRE_R2A;
      B_PRE_R2A: state_nxt = B_PRE_B;
      B_PRE_B:   state_nxt = B_PRE_BW;
      B_PRE_BW: begin
        if (m0_done) begin
          state_nxt = (card || bulb_r) ? B_DONE : B_CHECK;
        end
      end
      B_CHECK: begin
        if (go_on) begin
          state_nxt = B_IT_A;
        end else if (n_r == cfg.max_iterations) begin
          state_nxt = B_DONE;
        end else begin
          state_nxt = B_MOD;
        end
      end
      B_IT_A:  state_nxt = B_IT_AW;
      B_IT_AW: if (m0_done && m2_done) state_nxt = B_IT_B;
      B_IT_B:  state_nxt = B_IT_BW;
      B_IT_BW: if (m1_done) state_nxt = B_CHECK;
      B_MOD:   state_nxt = B_MODW;
      B_MODW:  if (d_done) state_nxt = B_SEG;
      B_SEG:   state_nxt = B_CH;
      B_CH:    state_nxt = B_CHW;
      B_CHW: begin
        if (d_done) begin
          state_nxt = (ch_r == CH_RED) ? B_DONE : B_CH;
        end
      end
      B_DONE:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= res_r;
    end
    unique case (state_r)
      B_IDLE: begin
        p_r  <= q_data.p;
        q_r  <= q_data.q;
        a_r  <= q_data.p - Q_QUARTER;
        b_r  <= q_data.p + Q_ONE;
        rc_r <= rc_in;
        rb_r <= rb_in;
        res_r <= '{blue: '0, green: '0, red: '0, inside_res: 1'b1};
      end
      B_PRE_AW: begin
        aa_r <= m0_res;
        qq_r <= m1_res;
        bb_r <= m2_res;
      end
      B_PRE_R2: begin
        r2_r   <= aa_r + qq_r;
        bulb_r <= rb_r && ((bb_r + qq_r) < Q_SIXTEENTH);
      end
      B_PRE_R2A: r2a_r <= r2_r + a_r;
      B_PRE_BW: begin
        x_r   <= '0;
        y_r   <= '0;
        x2_r  <= '0;
        dxy_r <= '0;
        esc_r <= '0;
        n_r   <= '0;
      end
      B_CHECK: xn_r <= sadd64(dxy_r, p_r);
      B_IT_AW: begin
        x2_r <= m0_res;
        x_r  <= xn_r;
        y_r  <= sadd64(m2_res, q_r);
      end
      B_IT_BW: begin
        // count the step once, when y*y is in
        if (m1_done) begin
          dxy_r <= x2_r - m1_res;
          esc_r <= {1'b0, x2_r} + {1'b0, m1_res};
          n_r   <= n_r + ITER_W'(1);
        end
      end
      B_MODW: k_r <= d_rem;
      B_SEG: begin
        res_r.inside_res <= 1'b0;
        ch_r <= CH_BLUE;
        if (k_r < cw1) begin
          seg_r <= SEG_LOW;
          kk_r  <= k_r[CW_W-1:0];
        end else if (k_r < cw2) begin
          seg_r <= SEG_MID;
          kk_r  <= CW_W'(k_r - cw1);
        end else begin
          seg_r <= SEG_HIGH;
          kk_r  <= CW_W'(k_r - cw2);
        end
      end
      B_CHW: begin
        if (d_done) begin
          ch_r <= ch_r + 2'd1;
          unique case (ch_r)
            CH_BLUE:  res_r.blue  <= ch_val;
            CH_GREEN: res_r.green <= ch_val;
            CH_RED:   res_r.red   <= ch_val;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

endmodule

`default_nettype wire
